// File: rtl/erwa_pkg.sv
package erwa_pkg;

    localparam int HISTORY_DEPTH_DEF = 3;
    localparam int OVERFLOW_SPAN_DEF = 256;
    localparam int QUEUE_DEPTH       = 2;

    localparam int TRIG_W     = 8;
    localparam int WAIT_W     = 16;
    localparam int OVL_W      = 8;
    localparam int FACTOR_W   = 16;
    localparam int DIST_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIST_W-1:0]   MAX_CM         = 12'd4095;
    localparam logic [TRIG_W-1:0]   TRIG_TICKS_RST = 8'd3;
    localparam logic [WAIT_W-1:0]   WAIT_LIMIT_RST = 16'd40000;
    localparam logic [OVL_W-1:0]    OVL_LIMIT_RST  = 8'd40;
    localparam logic [FACTOR_W-1:0] FACTOR_RST     = 16'd4496;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_TICKS   = 2'd0,
        CFG_ECHO_WAIT_LIMIT = 2'd1,
        CFG_OVERFLOW_LIMIT  = 2'd2,
        CFG_CM_PER_TICK     = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic trig;
        logic done;
        logic ok;
    } t_front_flags;

endpackage

// File: rtl/erwa_front.sv
module erwa_front #(
    parameter int OVERFLOW_SPAN = erwa_pkg::OVERFLOW_SPAN_DEF,
    localparam int CNT_W = $clog2((2 ** erwa_pkg::OVL_W) * OVERFLOW_SPAN + 2)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic                          i_start_req,
    input  logic                          i_echo,
    input  logic [erwa_pkg::TRIG_W-1:0]   i_trigger_ticks,
    input  logic [erwa_pkg::WAIT_W-1:0]   i_echo_wait_limit,
    input  logic [erwa_pkg::OVL_W-1:0]    i_overflow_limit,
    output erwa_pkg::t_front_flags        o_flags,
    output logic [CNT_W-1:0]              o_count
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_TRIG = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_MEAS = 4'b1000
    } t_phase;

    t_phase                        r_phase, n_phase;
    logic [erwa_pkg::WAIT_W-1:0]   r_pcnt, n_pcnt;
    logic [CNT_W-1:0]              r_ecnt, n_ecnt;
    logic [erwa_pkg::WAIT_W-1:0]   pcnt_inc;
    logic [CNT_W-1:0]              ecnt_inc;
    logic [CNT_W-1:0]              cap;
    erwa_pkg::t_front_flags        flags;

    assign pcnt_inc = r_pcnt + erwa_pkg::WAIT_W'(1);
    assign ecnt_inc = r_ecnt + CNT_W'(1);
    assign cap      = CNT_W'((CNT_W'(i_overflow_limit) + CNT_W'(1)) * CNT_W'(OVERFLOW_SPAN));

    always_comb begin
        n_phase = r_phase;
        n_pcnt  = r_pcnt;
        n_ecnt  = r_ecnt;
        flags   = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    flags.trig = 1'b1;
                    if (i_trigger_ticks <= erwa_pkg::TRIG_W'(1)) begin
                        n_phase = PH_WAIT;
                        n_pcnt  = '0;
                    end else begin
                        n_phase = PH_TRIG;
                        n_pcnt  = erwa_pkg::WAIT_W'(1);
                    end
                end
            end
            PH_TRIG: begin
                flags.trig = 1'b1;
                if (pcnt_inc >= erwa_pkg::WAIT_W'(i_trigger_ticks)) begin
                    n_phase = PH_WAIT;
                    n_pcnt  = '0;
                end else begin
                    n_pcnt = pcnt_inc;
                end
            end
            PH_WAIT: begin
                if (i_echo) begin
                    n_phase = PH_MEAS;
                    n_ecnt  = CNT_W'(1);
                end else begin
                    n_pcnt = pcnt_inc;
                    if (pcnt_inc >= i_echo_wait_limit) begin
                        flags.done = 1'b1;
                    end
                end
            end
            PH_MEAS: begin
                if (i_echo) begin
                    n_ecnt = ecnt_inc;
                    if (ecnt_inc > cap) begin
                        flags.done = 1'b1;
                    end
                end else begin
                    flags.done = 1'b1;
                    flags.ok   = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        if (flags.done) begin
            n_phase = PH_IDLE;
            n_pcnt  = '0;
            n_ecnt  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pcnt  <= '0;
            r_ecnt  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pcnt  <= n_pcnt;
            r_ecnt  <= n_ecnt;
        end
    end

    assign o_flags = flags;
    assign o_count = r_ecnt;

endmodule

// File: rtl/erwa_queue.sv
module erwa_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_valid,
    output logic              o_wr_ready,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic              o_rd_valid,
    input  logic              i_rd_ready,
    output logic [DATA_W-1:0] o_rd_data
);

    localparam int PTR_W = $clog2(erwa_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(erwa_pkg::QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [erwa_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_cnt;
    logic              push, pop;

    assign o_wr_ready = (r_cnt != CNT_W'(erwa_pkg::QUEUE_DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(erwa_pkg::QUEUE_DEPTH - 1)) ? '0
                          : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(erwa_pkg::QUEUE_DEPTH - 1)) ? '0
                          : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/erwa_back.sv
module erwa_back #(
    parameter int HISTORY_DEPTH = erwa_pkg::HISTORY_DEPTH_DEF,
    parameter int CNT_W = 17
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [erwa_pkg::FACTOR_W-1:0] i_factor,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  erwa_pkg::t_front_flags        i_flags,
    input  logic [CNT_W-1:0]              i_count,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_trigger,
    output logic                          o_done_res,
    output logic [erwa_pkg::DIST_W-1:0]   o_distance_cm
);

    localparam int DIST_W   = erwa_pkg::DIST_W;
    localparam int PROD_W   = CNT_W + erwa_pkg::FACTOR_W;
    localparam int SUM_W    = $clog2(HISTORY_DEPTH * (2 ** DIST_W - 1) + 1);
    localparam int SLOT_W   = $clog2(HISTORY_DEPTH);
    localparam int FILL_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int RECIP_SH = SUM_W + $clog2(HISTORY_DEPTH);
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int AVGP_W   = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** RECIP_SH + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_ZERO = 2'd1,
        K_AVG  = 2'd2,
        K_LAST = 2'd3
    } t_kind;

    logic                   rdy1, rdy2, rdy3;

    logic                   r_v1;
    erwa_pkg::t_front_flags r_f1;
    logic [PROD_W-1:0]      r_prod1;

    logic                   r_v2, r_trig2, r_done2;
    t_kind                  r_kind2;
    logic [SUM_W-1:0]       r_sum2;

    logic [DIST_W-1:0]      r_hist [HISTORY_DEPTH];
    logic [SLOT_W-1:0]      r_slot;
    logic [FILL_W-1:0]      r_fill;
    logic [SUM_W-1:0]       r_sum;

    logic                   r_v3, r_trig3, r_done3;
    logic [DIST_W-1:0]      r_dist3, r_last_avg;

    logic [CNT_W-1:0]       cm_raw;
    logic [DIST_W-1:0]      cm, old;
    logic                   take, full;
    logic [SUM_W-1:0]       sum_new;
    logic [FILL_W-1:0]      fill_new;
    t_kind                  kind;
    logic [AVGP_W-1:0]      avg_prod;
    logic [DIST_W-1:0]      avg, dist_sel;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    // ticks to cm
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_f1    <= i_flags;
            r_prod1 <= PROD_W'(i_count) * PROD_W'(i_factor);
        end
    end

    // history ring and running sum
    always_comb begin
        cm_raw   = r_prod1[PROD_W-1:erwa_pkg::FACTOR_W];
        cm       = (|cm_raw[CNT_W-1:DIST_W]) ? erwa_pkg::MAX_CM : cm_raw[DIST_W-1:0];
        full     = (r_fill == FILL_W'(HISTORY_DEPTH));
        old      = full ? r_hist[r_slot] : '0;
        sum_new  = r_sum - SUM_W'(old) + SUM_W'(cm);
        fill_new = full ? r_fill : r_fill + FILL_W'(1);
        take     = r_f1.done && r_f1.ok && (cm != '0);
        if (!r_f1.done) begin
            kind = K_NONE;
        end else if (take) begin
            kind = (fill_new == FILL_W'(HISTORY_DEPTH)) ? K_AVG : K_ZERO;
        end else begin
            kind = K_LAST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2   <= 1'b0;
            r_slot <= '0;
            r_fill <= '0;
            r_sum  <= '0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
            if (r_v1 && take) begin
                r_sum  <= sum_new;
                r_fill <= fill_new;
                r_slot <= (r_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                        : r_slot + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_trig2 <= r_f1.trig;
            r_done2 <= r_f1.done;
            r_kind2 <= kind;
            r_sum2  <= sum_new;
            if (take) begin
                r_hist[r_slot] <= cm;
            end
        end
    end

    // average by reciprocal multiply and output register
    always_comb begin
        avg_prod = AVGP_W'(r_sum2) * AVGP_W'(RECIP);
        avg      = avg_prod[RECIP_SH +: DIST_W];
        unique case (r_kind2)
            K_NONE:  dist_sel = '0;
            K_ZERO:  dist_sel = '0;
            K_AVG:   dist_sel = avg;
            K_LAST:  dist_sel = r_last_avg;
            default: dist_sel = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3       <= 1'b0;
            r_last_avg <= '0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
            if (r_v2 && r_kind2 == K_AVG) begin
                r_last_avg <= avg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_trig3 <= r_trig2;
            r_done3 <= r_done2;
            r_dist3 <= dist_sel;
        end
    end

    assign o_valid       = r_v3;
    assign o_trigger     = r_trig3;
    assign o_done_res    = r_done3;
    assign o_distance_cm = r_dist3;

endmodule

// File: rtl/echo_ranger_with_average_core.sv
// Ultrasonic echo ranger with a moving-average filter, one item per 4 us tick.
// Input channel (i_valid/o_ready): i_start_req and the sampled i_echo level.
// Output channel (o_valid/i_ready): exactly one item per input item, in order,
// carrying o_trigger (pin level for that tick), o_done_res (measurement ended)
// and o_distance_cm (filtered distance when done once the history is full, else 0).
// Configuration channel (i_cfg_valid/o_cfg_ready, always ready): i_cfg_index
// selects trigger_ticks, echo_wait_limit, overflow_limit or cm_per_tick_q16.
// Write configuration only while no item is in flight.
// An accepted item passes through the queue, the multiply stage, the filter
// stage and the output register, in that order.
// Throughput: one item per cycle while i_ready is high; the phase state machine
// in the front and the history/average registers in the back never stall it.
// A 2-entry queue separates the front from the back; when the receiver holds
// i_ready low the three back stages fill, then the queue, and o_ready drops
// once five items are held. No item is lost or repeated.
// Reset (synchronous, active low) returns the phase to idle, clears the
// history fill state and last average, and loads the default registers.
module echo_ranger_with_average_core #(
    parameter int HISTORY_DEPTH = erwa_pkg::HISTORY_DEPTH_DEF,
    parameter int OVERFLOW_SPAN = erwa_pkg::OVERFLOW_SPAN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_start_req,
    input  logic                            i_echo,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_trigger,
    output logic                            o_done_res,
    output logic [erwa_pkg::DIST_W-1:0]     o_distance_cm,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [erwa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [erwa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2((2 ** erwa_pkg::OVL_W) * OVERFLOW_SPAN + 2);
    localparam int FLG_W = $bits(erwa_pkg::t_front_flags);
    localparam int Q_W   = FLG_W + CNT_W;

    logic [erwa_pkg::TRIG_W-1:0]   r_trigger_ticks;
    logic [erwa_pkg::WAIT_W-1:0]   r_echo_wait_limit;
    logic [erwa_pkg::OVL_W-1:0]    r_overflow_limit;
    logic [erwa_pkg::FACTOR_W-1:0] r_cm_per_tick;

    erwa_pkg::t_front_flags        front_flags, back_flags;
    logic [CNT_W-1:0]              front_count, back_count;
    logic [Q_W-1:0]                q_rd_data;
    logic                          q_rd_valid, q_rd_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks   <= erwa_pkg::TRIG_TICKS_RST;
            r_echo_wait_limit <= erwa_pkg::WAIT_LIMIT_RST;
            r_overflow_limit  <= erwa_pkg::OVL_LIMIT_RST;
            r_cm_per_tick     <= erwa_pkg::FACTOR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (erwa_pkg::t_cfg_index'(i_cfg_index))
                erwa_pkg::CFG_TRIGGER_TICKS:
                    r_trigger_ticks <= i_cfg_data[erwa_pkg::TRIG_W-1:0];
                erwa_pkg::CFG_ECHO_WAIT_LIMIT:
                    r_echo_wait_limit <= i_cfg_data[erwa_pkg::WAIT_W-1:0];
                erwa_pkg::CFG_OVERFLOW_LIMIT:
                    r_overflow_limit <= i_cfg_data[erwa_pkg::OVL_W-1:0];
                erwa_pkg::CFG_CM_PER_TICK:
                    r_cm_per_tick <= i_cfg_data[erwa_pkg::FACTOR_W-1:0];
                default: ;
            endcase
        end
    end

    erwa_front #(
        .OVERFLOW_SPAN (OVERFLOW_SPAN)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (i_valid && o_ready),
        .i_start_req       (i_start_req),
        .i_echo            (i_echo),
        .i_trigger_ticks   (r_trigger_ticks),
        .i_echo_wait_limit (r_echo_wait_limit),
        .i_overflow_limit  (r_overflow_limit),
        .o_flags           (front_flags),
        .o_count           (front_count)
    );

    erwa_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_valid),
        .o_wr_ready (o_ready),
        .i_wr_data  ({front_flags, front_count}),
        .o_rd_valid (q_rd_valid),
        .i_rd_ready (q_rd_ready),
        .o_rd_data  (q_rd_data)
    );

    assign back_flags = erwa_pkg::t_front_flags'(q_rd_data[Q_W-1:CNT_W]);
    assign back_count = q_rd_data[CNT_W-1:0];

    erwa_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .CNT_W         (CNT_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_factor      (r_cm_per_tick),
        .i_valid       (q_rd_valid),
        .o_ready       (q_rd_ready),
        .i_flags       (back_flags),
        .i_count       (back_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_trigger     (o_trigger),
        .o_done_res    (o_done_res),
        .o_distance_cm (o_distance_cm)
    );

endmodule

// File: rtl/erwa_checker.sv
module erwa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_trigger,
    input logic                        o_done_res,
    input logic [erwa_pkg::DIST_W-1:0] o_distance_cm
);

    // a stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_distance_cm)
            && $stable(o_done_res) && $stable(o_trigger))
        else $error("output item changed while stalled");

    a_dist_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |-> o_distance_cm == '0)
        else $error("distance without a finished measurement");

    a_done_no_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_trigger)
        else $error("measurement ended while trigger high");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind echo_ranger_with_average_core erwa_checker u_erwa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_trigger     (o_trigger),
    .o_done_res    (o_done_res),
    .o_distance_cm (o_distance_cm)
);
